@@ sv/idb_pkg.sv @@
// ----------------------------------------------------------------------------
// idb_pkg: shared types and constants of the timed button debouncer
// Item, result and burst words, sizes and the debounce reset value.
// ----------------------------------------------------------------------------
package idb_pkg;

  localparam int PinWidth    = 4;
  localparam int ButtonCount = 4;
  localparam int WatchCount  = (ButtonCount < PinWidth) ? ButtonCount : PinWidth;
  localparam int IndexWidth  = $clog2(PinWidth);
  localparam int TickWidth   = 16;

  localparam logic [TickWidth-1:0] DebounceReset = TickWidth'(100);
  localparam logic [PinWidth-1:0]  AllReleased   = {PinWidth{1'b1}};
  localparam logic [PinWidth-1:0]  WatchMask     = AllReleased >> (PinWidth - WatchCount);

  localparam int QueueDepth      = 2;
  localparam int QueuePtrWidth   = $clog2(QueueDepth);
  localparam int QueueCountWidth = $clog2(QueueDepth + 1);

  typedef enum logic {
    OpTick = 1'b0,
    OpEdge = 1'b1
  } op_e;

  typedef struct packed {
    op_e                 op;
    logic [PinWidth-1:0] pins;
  } item_t;

  typedef struct packed {
    logic [IndexWidth-1:0] button_index;
    logic                  pressed;
    logic                  last;
  } result_t;

  typedef struct packed {
    logic [PinWidth-1:0] changed;
    logic [PinWidth-1:0] levels;
  } burst_t;

endpackage

@@ sv/idb_front.sv @@
// ----------------------------------------------------------------------------
// idb_front: debounce timer and level compare
// Takes tick and edge words, runs the wait and hands each change burst on.
// ----------------------------------------------------------------------------
module idb_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             take,
  input  idb_pkg::item_t                   item,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [idb_pkg::TickWidth-1:0]    cfg_data,
  output logic                             burst_push,
  output idb_pkg::burst_t                  burst
);

  logic [idb_pkg::TickWidth-1:0] debounce_ticks;
  logic                          debouncing;
  logic [idb_pkg::TickWidth-1:0] tick_count;
  logic [idb_pkg::PinWidth-1:0]  stable_levels;

  logic [idb_pkg::TickWidth-1:0] tick_inc;
  logic [idb_pkg::PinWidth-1:0]  changed;
  logic                          final_tick;

  assign cfg_ready = 1'b1;

  always_comb begin
    tick_inc   = tick_count + idb_pkg::TickWidth'(1);
    changed    = (item.pins ^ stable_levels) & idb_pkg::WatchMask;
    final_tick = debouncing && (item.op == idb_pkg::OpTick) && !(tick_inc < debounce_ticks);
  end

  assign burst_push     = take && final_tick && (changed != '0);
  assign burst.changed  = changed;
  assign burst.levels   = item.pins;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks <= idb_pkg::DebounceReset;
      debouncing     <= 1'b0;
      tick_count     <= '0;
      stable_levels  <= idb_pkg::AllReleased;
    end else begin
      if (cfg_valid) begin
        debounce_ticks <= cfg_data;
      end
      if (take) begin
        unique case (item.op)
          idb_pkg::OpEdge: begin
            if (!debouncing) begin
              debouncing <= 1'b1;
              tick_count <= '0;
            end
          end
          idb_pkg::OpTick: begin
            if (final_tick) begin
              debouncing    <= 1'b0;
              tick_count    <= '0;
              stable_levels <= item.pins;
            end else if (debouncing) begin
              tick_count <= tick_inc;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

@@ sv/idb_queue.sv @@
// ----------------------------------------------------------------------------
// idb_queue: short burst queue
// Holds change bursts between the timer and the result sequencer.
// ----------------------------------------------------------------------------
module idb_queue (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                wr,
  input  idb_pkg::burst_t                     wr_data,
  output logic                                full,
  input  logic                                rd,
  output idb_pkg::burst_t                     rd_data,
  output logic                                empty,
  output logic [idb_pkg::QueueCountWidth-1:0] count
);

  localparam logic [idb_pkg::QueuePtrWidth-1:0] LastPtr =
    idb_pkg::QueuePtrWidth'(idb_pkg::QueueDepth - 1);

  idb_pkg::burst_t                    mem [idb_pkg::QueueDepth];
  logic [idb_pkg::QueuePtrWidth-1:0]  wr_ptr;
  logic [idb_pkg::QueuePtrWidth-1:0]  rd_ptr;
  logic                               do_wr;
  logic                               do_rd;

  assign full    = (count == idb_pkg::QueueCountWidth'(idb_pkg::QueueDepth));
  assign empty   = (count == '0);
  assign do_wr   = wr && !full;
  assign do_rd   = rd && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + idb_pkg::QueuePtrWidth'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + idb_pkg::QueuePtrWidth'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + idb_pkg::QueueCountWidth'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - idb_pkg::QueueCountWidth'(1);
      end
    end
  end

endmodule

@@ sv/idb_back.sv @@
// ----------------------------------------------------------------------------
// idb_back: result sequencer
// Walks one change burst, lowest button first, into the result register.
// ----------------------------------------------------------------------------
module idb_back (
  input  logic             clk,
  input  logic             rst,
  input  idb_pkg::burst_t  head,
  input  logic             q_empty,
  output logic             q_pop,
  output idb_pkg::result_t result,
  output logic             empty,
  input  logic             pop
);

  logic [idb_pkg::PinWidth-1:0]   cur_mask;
  logic [idb_pkg::PinWidth-1:0]   cur_levels;
  logic                           out_valid;
  idb_pkg::result_t               out_word;

  logic                           advance;
  logic                           emit;
  logic                           load;
  logic [idb_pkg::IndexWidth-1:0] sel;
  logic [idb_pkg::PinWidth-1:0]   rest;
  idb_pkg::result_t               out_next;

  always_comb begin
    sel = '0;
    for (int i = idb_pkg::PinWidth - 1; i >= 0; i--) begin
      if (cur_mask[i]) begin
        sel = idb_pkg::IndexWidth'(i);
      end
    end
    rest                  = cur_mask & ~(idb_pkg::PinWidth'(1) << sel);
    advance               = !out_valid || pop;
    emit                  = advance && (cur_mask != '0);
    load                  = (cur_mask == '0) && !q_empty;
    out_next.button_index = sel;
    out_next.pressed      = !cur_levels[sel];
    out_next.last         = (rest == '0);
  end

  assign q_pop  = load;
  assign empty  = !out_valid;
  assign result = out_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_mask  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        cur_mask <= head.changed;
      end else if (emit) begin
        cur_mask <= rest;
      end
      if (advance) begin
        out_valid <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur_levels <= head.levels;
    end
    if (emit) begin
      out_word <= out_next;
    end
  end

endmodule

@@ sv/irq_timed_button_debouncer.sv @@
// ----------------------------------------------------------------------------
// irq_timed_button_debouncer: tick and edge driven button debouncer
// Waits a set number of ticks after an edge, then reports changed buttons.
// ----------------------------------------------------------------------------
//  channel  | handshake            | word
//  ---------+----------------------+---------------------------------------
//  item     | push / full          | op, pins
//  result   | pop / empty          | button_index, pressed, last
//  config   | cfg_valid / cfg_ready| cfg_data = debounce_ticks
//
//  An item is taken every cycle while full is low; the timer updates in
//  that cycle. Full rises only while two change bursts wait in the queue.
//  Results leave one per cycle while pop is high, pausing as the sequencer
//  loads the next burst from the queue. Reset (rst, synchronous) clears the
//  wait, stores all buttons released and sets debounce_ticks to 100.
// ----------------------------------------------------------------------------
module irq_timed_button_debouncer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  idb_pkg::item_t                item,
  output logic                          empty,
  input  logic                          pop,
  output idb_pkg::result_t              result,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [idb_pkg::TickWidth-1:0] cfg_data
);

  logic                                take;
  logic                                burst_push;
  idb_pkg::burst_t                     burst;
  idb_pkg::burst_t                     head;
  logic                                q_full;
  logic                                q_empty;
  logic                                q_pop;
  logic [idb_pkg::QueueCountWidth-1:0] q_count;

  assign full = q_full;
  assign take = push && !q_full;

  idb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .item       (item),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .burst_push (burst_push),
    .burst      (burst)
  );

  idb_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (burst_push),
    .wr_data (burst),
    .full    (q_full),
    .rd      (q_pop),
    .rd_data (head),
    .empty   (q_empty),
    .count   (q_count)
  );

  idb_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .result  (result),
    .empty   (empty),
    .pop     (pop)
  );

  a_queue_bound : assert property (@(posedge clk) disable iff (rst)
    q_count <= idb_pkg::QueueCountWidth'(idb_pkg::QueueDepth))
    else $error("burst queue count beyond depth");

  a_edge_no_burst : assert property (@(posedge clk) disable iff (rst)
    (take && (item.op == idb_pkg::OpEdge)) |-> !burst_push)
    else $error("edge word produced a change burst");

  a_burst_nonzero : assert property (@(posedge clk) disable iff (rst)
    burst_push |-> (burst.changed != '0))
    else $error("empty change burst queued");

  a_reset_empty : assert property (@(posedge clk)
    $past(rst) |-> empty)
    else $error("result pending right after reset");

endmodule

@@ bench/tb_irq_timed_button_debouncer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_irq_timed_button_debouncer: self-checking bench for the button debouncer
// Drives tick and edge words through the push/full side and pops change
// results at random. A built-in model of the debounce timer and the stored
// levels predicts the results of the random words; a short table of directed
// words with their own expected results comes first, then random debounce
// sequences under several wait lengths, with 0, 1 and 65535 among them.
// ----------------------------------------------------------------------------
module tb_irq_timed_button_debouncer;

  localparam int HalfPeriod = 6;
  localparam int StallLimit = 2000;
  localparam int DrainCycles = 12;
  localparam int ResetRows = 5;

  typedef struct {
    idb_pkg::item_t   word;
    int               reps;
    bit               typed;
    int               n;
    idb_pkg::result_t r [4];
  } dir_row_t;

  logic                          clk;
  logic                          rst;
  logic                          push;
  logic                          full;
  idb_pkg::item_t                item;
  logic                          empty;
  logic                          pop;
  idb_pkg::result_t              result;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [idb_pkg::TickWidth-1:0] cfg_data;

  logic [idb_pkg::TickWidth-1:0] hold_ticks;
  logic [idb_pkg::TickWidth-1:0] ticks_seen;
  logic [idb_pkg::PinWidth-1:0]  settled_pins;
  bit                            wait_active;

  idb_pkg::result_t pending_changes [$];
  dir_row_t         dir_plan [$];
  int               mismatches;
  int               live_words;
  int               quiet_cycles;
  int               pop_stall;
  bit               idle_on;

  irq_timed_button_debouncer u_dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #HalfPeriod clk = ~clk;

  function automatic void debounce_step(input idb_pkg::item_t w,
                                        output idb_pkg::result_t res [4],
                                        output int n, output bit live);
    n = 0;
    live = 0;
    if (w.op == idb_pkg::OpEdge) begin
      if (!wait_active) begin
        wait_active = 1;
        ticks_seen = '0;
        live = 1;
      end
      return;
    end
    if (!wait_active) return;
    live = 1;
    ticks_seen = ticks_seen + idb_pkg::TickWidth'(1);
    if (ticks_seen < hold_ticks) return;
    wait_active = 0;
    ticks_seen = '0;
    if (w.pins == settled_pins) return;
    for (int i = 0; i < idb_pkg::WatchCount; i++) begin
      if (w.pins[i] != settled_pins[i]) begin
        res[n] = idb_pkg::result_t'{idb_pkg::IndexWidth'(i), ~w.pins[i], 1'b0};
        n++;
      end
    end
    if (n > 0) res[n-1].last = 1'b1;
    settled_pins = w.pins;
  endfunction

  function automatic dir_row_t pick_row(input idb_pkg::op_e op);
    dir_row_t row;
    row.word.op = op;
    row.word.pins = idb_pkg::PinWidth'($urandom_range(0, 15));
    row.reps = 1;
    row.typed = 0;
    row.n = 0;
    return row;
  endfunction

  task automatic add_row(input idb_pkg::op_e op, input logic [idb_pkg::PinWidth-1:0] pins,
                         input int reps, input bit typed, input int n,
                         input idb_pkg::result_t r0, input idb_pkg::result_t r1,
                         input idb_pkg::result_t r2, input idb_pkg::result_t r3);
    dir_row_t row;
    row.word.op = op;
    row.word.pins = pins;
    row.reps = reps;
    row.typed = typed;
    row.n = n;
    row.r[0] = r0;
    row.r[1] = r1;
    row.r[2] = r2;
    row.r[3] = r3;
    dir_plan.push_back(row);
  endtask

  task automatic send_item(input dir_row_t row);
    idb_pkg::result_t res [4];
    int               n;
    bit               live;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    push <= 1'b1;
    item <= row.word;
    do @(posedge clk); while (full);
    debounce_step(row.word, res, n, live);
    if (live) live_words++;
    if (row.typed) begin
      for (int i = 0; i < row.n; i++) pending_changes.push_back(row.r[i]);
    end else begin
      for (int i = 0; i < n; i++) pending_changes.push_back(res[i]);
    end
    @(negedge clk);
  endtask

  task automatic write_hold(input logic [idb_pkg::TickWidth-1:0] value);
    push <= 1'b0;
    while (pending_changes.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    hold_ticks = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(input int target);
    int base;
    int k;
    base = live_words;
    while (live_words - base < target) begin
      if ($urandom_range(0, 3) != 0) begin
        send_item(pick_row(idb_pkg::OpEdge));
        k = (hold_ticks > 1) ? int'(hold_ticks) - 1 : 0;
        repeat (k) begin
          if ($urandom_range(0, 4) == 0) send_item(pick_row(idb_pkg::OpEdge));
          send_item(pick_row(idb_pkg::OpTick));
        end
        send_item(pick_row(idb_pkg::OpTick));
      end else begin
        send_item(pick_row(idb_pkg::op_e'($urandom_range(0, 1))));
      end
    end
  endtask

  always @(negedge clk) begin
    if (pop_stall > 0) begin
      pop_stall <= pop_stall - 1;
      pop <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      pop_stall <= $urandom_range(0, 7);
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  always @(posedge clk) begin
    idb_pkg::result_t want;
    if (!rst && pop && !empty) begin
      if (pending_changes.size() == 0) begin
        $display("%0t: unexpected word idx=%0d pressed=%0b last=%0b", $time,
                 result.button_index, result.pressed, result.last);
        mismatches++;
      end else begin
        want = pending_changes.pop_front();
        if (result.button_index !== want.button_index || result.pressed !== want.pressed ||
            result.last !== want.last) begin
          $display("%0t: expected idx=%0d pressed=%0b last=%0b, got idx=%0d pressed=%0b last=%0b",
                   $time, want.button_index, want.pressed, want.last,
                   result.button_index, result.pressed, result.last);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    idb_pkg::result_t none;
    none = '0;
    clk = 1'b0;
    rst = 1'b1;
    push = 1'b0;
    item = '0;
    pop = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    mismatches = 0;
    live_words = 0;
    quiet_cycles = 0;
    pop_stall = 0;
    idle_on = 1;
    hold_ticks = idb_pkg::DebounceReset;
    ticks_seen = '0;
    settled_pins = idb_pkg::AllReleased;
    wait_active = 0;

    // tick while idle, edge starts the wait, edge during the wait is dropped
    add_row(idb_pkg::OpTick, 4'h0, 1, 1, 0, none, none, none, none);
    add_row(idb_pkg::OpEdge, 4'hE, 1, 1, 0, none, none, none, none);
    add_row(idb_pkg::OpEdge, 4'h0, 1, 1, 0, none, none, none, none);
    add_row(idb_pkg::OpTick, 4'hE, 99, 1, 0, none, none, none, none);
    add_row(idb_pkg::OpTick, 4'h0, 1, 1, 4,
            idb_pkg::result_t'{2'd0, 1'b1, 1'b0}, idb_pkg::result_t'{2'd1, 1'b1, 1'b0},
            idb_pkg::result_t'{2'd2, 1'b1, 1'b0}, idb_pkg::result_t'{2'd3, 1'b1, 1'b1});
    // final tick with no change
    add_row(idb_pkg::OpEdge, 4'hF, 1, 1, 0, none, none, none, none);
    add_row(idb_pkg::OpTick, 4'h3, 1, 1, 0, none, none, none, none);
    add_row(idb_pkg::OpTick, 4'h0, 1, 1, 0, none, none, none, none);
    add_row(idb_pkg::OpEdge, 4'h0, 1, 1, 0, none, none, none, none);
    add_row(idb_pkg::OpTick, 4'hF, 1, 1, 0, none, none, none, none);
    add_row(idb_pkg::OpTick, 4'h5, 1, 1, 2,
            idb_pkg::result_t'{2'd0, 1'b0, 1'b0}, idb_pkg::result_t'{2'd2, 1'b0, 1'b1},
            none, none);
    add_row(idb_pkg::OpEdge, 4'h5, 1, 1, 0, none, none, none, none);
    add_row(idb_pkg::OpTick, 4'h0, 1, 1, 0, none, none, none, none);
    add_row(idb_pkg::OpTick, 4'hA, 1, 1, 4,
            idb_pkg::result_t'{2'd0, 1'b1, 1'b0}, idb_pkg::result_t'{2'd1, 1'b0, 1'b0},
            idb_pkg::result_t'{2'd2, 1'b1, 1'b0}, idb_pkg::result_t'{2'd3, 1'b0, 1'b1});
    add_row(idb_pkg::OpEdge, 4'hA, 1, 1, 0, none, none, none, none);
    add_row(idb_pkg::OpEdge, 4'h1, 1, 1, 0, none, none, none, none);
    add_row(idb_pkg::OpTick, 4'h6, 1, 1, 0, none, none, none, none);
    add_row(idb_pkg::OpTick, 4'hF, 1, 1, 2,
            idb_pkg::result_t'{2'd0, 1'b0, 1'b0}, idb_pkg::result_t'{2'd2, 1'b0, 1'b1},
            none, none);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_plan[i]) begin
      // shorten the wait once the reset-length wait is done
      if (i == ResetRows) write_hold(16'd2);
      repeat (dir_plan[i].reps) send_item(dir_plan[i]);
    end

    write_hold(16'd1);
    run_random(50);
    // zero wait behaves as a one-tick wait
    write_hold(16'd0);
    run_random(30);

    // longest wait, then lower the register while a wait is running
    write_hold(16'hFFFF);
    idle_on = 0;
    send_item(pick_row(idb_pkg::OpEdge));
    repeat (3) send_item(pick_row(idb_pkg::OpTick));
    write_hold(16'd2);
    send_item(pick_row(idb_pkg::OpTick));
    idle_on = 1;
    run_random(50);

    write_hold(16'd3);
    run_random(50);
    write_hold(16'd7);
    run_random(40);

    write_hold(16'd1);
    idle_on = 0;
    run_random(30);

    push <= 1'b0;
    while (pending_changes.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0 && pending_changes.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
